@@ design/bpm_pkg.sv @@
package bpm_pkg;

  localparam int LETTER_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef struct packed {
    letter_t word;
    letter_t pattern;
    logic    last;
  } item_t;

  typedef struct packed {
    logic    en;
    letter_t addr;
    letter_t data;
  } map_wr_t;

endpackage

@@ design/bpm_if.sv @@
interface bpm_letter_if;
  logic             valid;
  logic             ready;
  bpm_pkg::letter_t word_letter;
  bpm_pkg::letter_t pattern_letter;
  logic             last_letter;

  modport source (output valid, word_letter, pattern_letter, last_letter, input ready);
  modport sink (input valid, word_letter, pattern_letter, last_letter, output ready);
endinterface

interface bpm_result_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

@@ design/bpm_map_ram.sv @@
module bpm_map_ram #(
  parameter int DEPTH = 26
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [$clog2(DEPTH)-1:0]   rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [$clog2(DEPTH)-1:0]   wr_data
);
  localparam int IDX_W = $clog2(DEPTH);

  logic [IDX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ design/bpm_check.sv @@
module bpm_check #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  bpm_pkg::item_t                   item,
  input  logic [$clog2(ALPHABET_SIZE)-1:0] map_data,
  output bpm_pkg::map_wr_t                 wr,
  output logic                             matched
);
  import bpm_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET_SIZE);

  logic [ALPHABET_SIZE-1:0] word_seen, word_seen_next;
  logic [ALPHABET_SIZE-1:0] pat_seen, pat_seen_next;
  logic                     failed, failed_next;
  logic                     fwd_valid;
  logic [IDX_W-1:0]         fwd_addr;
  logic [IDX_W-1:0]         fwd_data;

  logic [IDX_W-1:0] w_idx, p_idx, mapped;
  logic             out_of_range, fail_now, do_write;

  assign w_idx = item.word[IDX_W-1:0];
  assign p_idx = item.pattern[IDX_W-1:0];

  assign out_of_range = ({1'b0, item.word} >= (LETTER_W+1)'(ALPHABET_SIZE)) ||
                        ({1'b0, item.pattern} >= (LETTER_W+1)'(ALPHABET_SIZE));

  // latest write bypasses the memory read issued in the same cycle
  assign mapped = (fwd_valid && fwd_addr == w_idx) ? fwd_data : map_data;

  always_comb begin
    fail_now = out_of_range || (word_seen[w_idx] ? (mapped != p_idx) : pat_seen[p_idx]);
    do_write = advance && !failed && !fail_now;
    matched  = !(failed || fail_now);

    wr.en   = do_write;
    wr.addr = item.word;
    wr.data = item.pattern;

    word_seen_next = word_seen;
    pat_seen_next  = pat_seen;
    failed_next    = failed;
    if (advance) begin
      if (item.last) begin
        word_seen_next = '0;
        pat_seen_next  = '0;
        failed_next    = 1'b0;
      end else if (do_write) begin
        word_seen_next = word_seen | (ALPHABET_SIZE'(1) << w_idx);
        pat_seen_next  = pat_seen | (ALPHABET_SIZE'(1) << p_idx);
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_seen <= '0;
      pat_seen  <= '0;
      failed    <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      word_seen <= word_seen_next;
      pat_seen  <= pat_seen_next;
      failed    <= failed_next;
      if (do_write) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      fwd_addr <= w_idx;
      fwd_data <= p_idx;
    end
  end
endmodule

@@ design/bijective_pattern_match_unit.sv @@
// The last letter waits in s1 while a result is held, then its result is registered.
// Throughput: otherwise one letter request per cycle, set by the single read/write port
// pair of the word-to-pattern map memory; the same-entry hazard is covered by a bypass.
// Reset (synchronous): clears pipeline and output valid, seen bits and the fail flag;
// map memory contents are left as they are and need no clearing pass.
module bijective_pattern_match_unit #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic         clk,
  input  logic         rst,
  bpm_letter_if.sink   letter,
  bpm_result_if.source result
);
  import bpm_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET_SIZE);

  item_t            s1;
  logic             s1_valid;
  logic             s1_adv;
  logic             accept;
  logic [IDX_W-1:0] map_data;
  map_wr_t          wr;
  logic             matched_now;
  logic             out_valid;
  logic             out_matched;

  assign s1_adv       = s1_valid && (!s1.last || !out_valid || result.ready);
  assign letter.ready = !s1_valid || s1_adv;
  assign accept       = letter.valid && letter.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (letter.ready) begin
      s1_valid <= letter.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.word    <= letter.word_letter;
      s1.pattern <= letter.pattern_letter;
      s1.last    <= letter.last_letter;
    end
  end

  bpm_map_ram #(.DEPTH(ALPHABET_SIZE)) u_map (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (letter.word_letter[IDX_W-1:0]),
    .rd_data (map_data),
    .wr_en   (wr.en),
    .wr_addr (wr.addr[IDX_W-1:0]),
    .wr_data (wr.data[IDX_W-1:0])
  );

  bpm_check #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_check (
    .clk      (clk),
    .rst      (rst),
    .advance  (s1_adv),
    .item     (s1),
    .map_data (map_data),
    .wr       (wr),
    .matched  (matched_now)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.last) begin
      out_matched <= matched_now;
    end
  end

  assign result.valid   = out_valid;
  assign result.matched = out_matched;

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ({1'b0, wr.addr} < (LETTER_W+1)'(ALPHABET_SIZE)) &&
              ({1'b0, wr.data} < (LETTER_W+1)'(ALPHABET_SIZE)))
    else $error("map write with letter outside alphabet");

  a_wr_only_on_adv: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_adv)
    else $error("map write from stalled stage");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s1_adv && s1.last))
    else $error("result without last letter");
endmodule
